[hdl/epidemic_chain_trajectory_top_macros.svh]
// Assertion macros for the epidemic chain trajectory block
`ifndef EPIDEMIC_CHAIN_TRAJECTORY_TOP_MACROS_SVH
`define EPIDEMIC_CHAIN_TRAJECTORY_TOP_MACROS_SVH
`ifndef SYNTH
`define ECT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ect assertion failed");
`define ECT_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("ect forbidden condition");
`else
`define ECT_ASSERT(lbl, clk, rst_n, prop)
`define ECT_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

[hdl/ect_pkg.sv]
// Shared types, constants and constant tables of the epidemic chain trajectory block
`timescale 1ns / 1ps
package ect_pkg;

  localparam int unsigned MaxEpochsDefault  = 64;
  localparam int unsigned PopFracDefault    = 12;
  localparam int unsigned LogFrac           = 24;
  localparam int unsigned ExpBits           = 20;
  localparam int unsigned PopWidth          = 32;
  localparam logic [15:0] TransmitReset     = 16'd655;
  localparam logic [6:0]  EpochCountReset   = 7'd16;

  localparam logic CfgTransmit = 1'b0;
  localparam logic CfgEpochs   = 1'b1;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_LOG_MUL = 10'b0000000010,
    S_LOG_UPD = 10'b0000000100,
    S_EMIT    = 10'b0000001000,
    S_E_MUL   = 10'b0000010000,
    S_E_WAIT  = 10'b0000100000,
    S_X_MUL   = 10'b0001000000,
    S_X_UPD   = 10'b0010000000,
    S_N_MUL   = 10'b0100000000,
    S_N_UPD   = 10'b1000000000
  } ect_state_e;

  typedef struct packed {
    logic [5:0]  epoch_index;
    logic [31:0] susceptible;
    logic [31:0] infected;
    logic [31:0] recovered;
    logic        last_epoch;
  } ect_res_t;

  typedef logic [ExpBits-1:0][31:0] exp_tab_t;

  function automatic logic [63:0] floor_sqrt64(input logic [63:0] x);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bitv;
    rem  = x;
    res  = '0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // factor 2^(-2^-j) for j = 1..ExpBits, entry j-1
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    logic [63:0] t;
    t = floor_sqrt64(64'd1 << 63);
    for (int j = 0; j < ExpBits; j++) begin
      tab[j] = t[31:0];
      t = floor_sqrt64({t[31:0], 32'd0});
    end
    return tab;
  endfunction

  localparam exp_tab_t ExpTab = build_exp_tab();

endpackage

[hdl/ect_mul.sv]
// Shared 32x32 multiplier with registered product
`timescale 1ns / 1ps
module ect_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);
  logic [63:0] p_q;
  logic [63:0] p_d;

  assign p_d = 64'(a_i) * 64'(b_i);

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;
endmodule

[hdl/ect_out.sv]
// Output register stage for result items
`timescale 1ns / 1ps
module ect_out (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  ect_pkg::ect_res_t res_i,
  output logic              can_load_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ect_pkg::ect_res_t res_o
);
  import ect_pkg::*;

  logic     valid_q;
  logic     valid_d;
  ect_res_t res_q;

  assign can_load_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;
endmodule

[hdl/epidemic_chain_trajectory_top.sv]
// Top level of the Reed-Frost epidemic trajectory generator
//
// Input channel (in_valid_i/in_ready_o) takes one run request: initial
// susceptible, infected and recovered populations, unsigned fixed point.
// Config channel (cfg_valid_i/cfg_ready_o) writes index 0 transmit
// probability (Q0.16) and index 1 epoch count; always ready.
// Output channel (out_valid_o/out_ready_i) gives one item per epoch, epoch 0
// being the initial conditions, last_epoch set on the final item.
// Sequencing: all multiplications go through one registered 32x32 multiplier
// under a sequencer. The log2 of 1-p takes 24 square steps before epoch 0
// is emitted. Each later epoch takes one product, 20 exponent steps, one
// product and an update. The next request is accepted once the last item
// is registered. A stalled receiver holds the sequencer at its emit step
// while the output register is full. Reset clears the sequencer and output
// valid and loads the register defaults (p = 655, 16 epochs).
`timescale 1ns / 1ps
module epidemic_chain_trajectory_top #(
  parameter int unsigned MAX_EPOCHS        = ect_pkg::MaxEpochsDefault,
  parameter int unsigned POP_FRACTION_BITS = ect_pkg::PopFracDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] initial_susceptible_i,
  input  logic [31:0] initial_infected_i,
  input  logic [31:0] initial_recovered_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  epoch_index_o,
  output logic [31:0] susceptible_o,
  output logic [31:0] infected_o,
  output logic [31:0] recovered_o,
  output logic        last_epoch_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import ect_pkg::*;
  `include "epidemic_chain_trajectory_top_macros.svh"

  localparam int unsigned CW = $clog2(MAX_EPOCHS + 1);
  localparam int unsigned FB = POP_FRACTION_BITS + LogFrac;

  ect_state_e  state_q, state_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [CW-1:0] epoch_q, epoch_d, count_q, count_d;
  logic [15:0] prob_q, prob_d;
  logic [6:0]  ecount_q, ecount_d;
  logic [31:0] m_q, m_d;
  logic [23:0] frac_q, frac_d;
  logic [4:0]  n_q, n_d;
  logic [31:0] l_q, l_d;
  logic [31:0] s_q, s_d, i_q, i_d, r_q, r_d;
  logic [4:0]  k_q, k_d;
  logic        kbig_q, kbig_d;
  logic [ExpBits-1:0] f_q, f_d;
  logic [32:0] rr_q, rr_d;
  logic        szero_q, szero_d;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic        load, can_load, last;
  ect_res_t    res_in, res_out;

  logic [16:0] q;
  logic [4:0]  n_new;
  logic [32:0] sq;
  logic [23:0] frac_new;
  logic [32:0] surv, omsurv;
  logic [31:0] ni;
  logic [32:0] rsum;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign last        = (epoch_q == count_q - CW'(1));

  always_comb begin
    q = 17'(17'h10000 - {1'b0, prob_q});
    n_new = '0;
    for (int b = 0; b < 17; b++) begin
      if (q[b]) begin
        n_new = 5'(b);
      end
    end
    sq       = prod[63:31];
    frac_new = {frac_q[22:0], sq[32]};
    surv     = kbig_q ? 33'd0 : (rr_q >> k_q);
    omsurv   = 33'(33'h1_0000_0000 - surv);
    ni       = szero_q ? s_q : prod[63:32];
    if (ni > s_q) begin
      ni = s_q;
    end
    rsum = {1'b0, r_q} + {1'b0, i_q};
  end

  always_comb begin
    mul_a = m_q;
    mul_b = m_q;
    unique case (state_q)
      S_E_MUL: begin
        mul_a = i_q;
        mul_b = l_q;
      end
      S_X_MUL: begin
        mul_a = rr_q[31:0];
        mul_b = ExpTab[cnt_q];
      end
      S_N_MUL: begin
        mul_a = s_q;
        mul_b = omsurv[31:0];
      end
      default: begin
        mul_a = m_q;
        mul_b = m_q;
      end
    endcase
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    epoch_d  = epoch_q;
    count_d  = count_q;
    prob_d   = prob_q;
    ecount_d = ecount_q;
    m_d      = m_q;
    frac_d   = frac_q;
    n_d      = n_q;
    l_d      = l_q;
    s_d      = s_q;
    i_d      = i_q;
    r_d      = r_q;
    k_d      = k_q;
    kbig_d   = kbig_q;
    f_d      = f_q;
    rr_d     = rr_q;
    szero_d  = szero_q;
    load     = 1'b0;

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgTransmit: prob_d   = cfg_data_i;
        CfgEpochs:   ecount_d = cfg_data_i[6:0];
        default:     prob_d   = prob_q;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          s_d     = initial_susceptible_i;
          i_d     = initial_infected_i;
          r_d     = initial_recovered_i;
          epoch_d = '0;
          if (ecount_q == 7'd0) begin
            count_d = CW'(1);
          end else if (ecount_q > 7'(MAX_EPOCHS)) begin
            count_d = CW'(MAX_EPOCHS);
          end else begin
            count_d = CW'(ecount_q);
          end
          n_d     = n_new;
          m_d     = 32'(q) << (5'd31 - n_new);
          frac_d  = '0;
          cnt_d   = '0;
          state_d = S_LOG_MUL;
        end
      end
      S_LOG_MUL: state_d = S_LOG_UPD;
      S_LOG_UPD: begin
        m_d    = sq[32] ? sq[32:1] : sq[31:0];
        frac_d = frac_new;
        cnt_d  = cnt_q + 5'd1;
        if (cnt_q == 5'(LogFrac - 1)) begin
          l_d     = 32'(32'd16 << LogFrac) - ((32'(n_q) << LogFrac) | 32'(frac_new));
          state_d = S_EMIT;
        end else begin
          state_d = S_LOG_MUL;
        end
      end
      S_EMIT: begin
        if (can_load) begin
          load    = 1'b1;
          state_d = last ? S_IDLE : S_E_MUL;
        end
      end
      S_E_MUL: state_d = S_E_WAIT;
      S_E_WAIT: begin
        kbig_d  = |prod[63:FB+5];
        k_d     = prod[FB+4:FB];
        f_d     = prod[FB-1:FB-ExpBits];
        rr_d    = 33'h1_0000_0000;
        cnt_d   = '0;
        state_d = S_X_MUL;
      end
      S_X_MUL: state_d = S_X_UPD;
      S_X_UPD: begin
        if (f_q[ExpBits-1]) begin
          rr_d = rr_q[32] ? {1'b0, ExpTab[cnt_q]} : {1'b0, prod[63:32]};
        end
        f_d   = f_q << 1;
        cnt_d = cnt_q + 5'd1;
        state_d = (cnt_q == 5'(ExpBits - 1)) ? S_N_MUL : S_X_MUL;
      end
      S_N_MUL: begin
        szero_d = (surv == 33'd0);
        state_d = S_N_UPD;
      end
      S_N_UPD: begin
        s_d     = s_q - ni;
        r_d     = rsum[32] ? 32'hFFFF_FFFF : rsum[31:0];
        i_d     = ni;
        epoch_d = epoch_q + CW'(1);
        state_d = S_EMIT;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      epoch_q  <= '0;
      count_q  <= CW'(1);
      prob_q   <= TransmitReset;
      ecount_q <= EpochCountReset;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      epoch_q  <= epoch_d;
      count_q  <= count_d;
      prob_q   <= prob_d;
      ecount_q <= ecount_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q     <= m_d;
    frac_q  <= frac_d;
    n_q     <= n_d;
    l_q     <= l_d;
    s_q     <= s_d;
    i_q     <= i_d;
    r_q     <= r_d;
    k_q     <= k_d;
    kbig_q  <= kbig_d;
    f_q     <= f_d;
    rr_q    <= rr_d;
    szero_q <= szero_d;
  end

  ect_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign res_in.epoch_index = 6'(epoch_q);
  assign res_in.susceptible = s_q;
  assign res_in.infected    = i_q;
  assign res_in.recovered   = r_q;
  assign res_in.last_epoch  = last;

  ect_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .res_i       (res_in),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_out)
  );

  assign epoch_index_o = res_out.epoch_index;
  assign susceptible_o = res_out.susceptible;
  assign infected_o    = res_out.infected;
  assign recovered_o   = res_out.recovered;
  assign last_epoch_o  = res_out.last_epoch;

  `ECT_ASSERT(a_accept_starts_log, clk_i, rst_ni,
    (in_valid_i && in_ready_o) |=> (state_q == S_LOG_MUL))
  `ECT_ASSERT(a_last_returns_idle, clk_i, rst_ni,
    (load && last) |=> (state_q == S_IDLE))
  `ECT_ASSERT_NEVER(a_epoch_in_range, clk_i, rst_ni,
    (state_q != S_IDLE) && (epoch_q >= count_q))
  `ECT_ASSERT_NEVER(a_load_when_full, clk_i, rst_ni,
    load && out_valid_o && !out_ready_i)
endmodule

[verif/epidemic_chain_trajectory_top_tb.sv]
// Self-checking testbench of the epidemic chain trajectory block
`timescale 1ns / 1ps
module epidemic_chain_trajectory_top_tb;
  import ect_pkg::*;

  typedef struct packed {
    logic [5:0]  epoch_index;
    logic [31:0] susceptible;
    logic [31:0] infected;
    logic [31:0] recovered;
    logic        last_epoch;
  } epoch_rec_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] initial_susceptible_i = '0;
  logic [31:0] initial_infected_i = '0;
  logic [31:0] initial_recovered_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [5:0]  epoch_index_o;
  logic [31:0] susceptible_o;
  logic [31:0] infected_o;
  logic [31:0] recovered_o;
  logic        last_epoch_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = CfgTransmit;
  logic [15:0] cfg_data_i = '0;

  logic [15:0] prob_q = 16'd655;
  logic [6:0]  epochs_q = 7'd16;
  epoch_rec_t  trajectory_q[$];
  int          fail_cnt = 0;
  int          cycle_cnt = 0;
  int          hold_off = 0;
  int          rx_gap = 0;
  bit          rx_idle_en = 1'b1;
  bit          tx_idle_en = 1'b1;

  epidemic_chain_trajectory_top dut (.*);

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 4000000) begin
      $display("epidemic_chain_trajectory_top_tb: FAIL");
      $finish;
    end
  end

  function automatic logic [63:0] isqrt(input logic [63:0] x);
    logic [63:0] rem, res, b;
    rem = x;
    res = '0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] neg_log2(input logic [16:0] q);
    int unsigned n;
    logic [31:0] frac;
    logic [63:0] m;
    n = 0;
    frac = '0;
    while (n < 16 && (q >> (n + 1)) != 0) n++;
    m = 64'(q) << (31 - n);
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= (64'd1 << 32)) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    return (32'd16 << 24) - ((32'(n) << 24) + frac);
  endfunction

  function automatic logic [63:0] survival_frac(input logic [31:0] inf, input logic [31:0] l);
    logic [63:0] e, k, f, r, t;
    e = 64'(inf) * 64'(l);
    k = e >> 36;
    f = (e >> 16) & 64'hFFFFF;
    r = 64'd1 << 32;
    t = isqrt(64'd1 << 63);
    if (k >= 32) return 64'd0;
    for (int j = 1; j <= 20; j++) begin
      if ((f >> (20 - j)) & 1) r = (r * t) >> 32;
      t = isqrt(t << 32);
    end
    return r >> k;
  endfunction

  task automatic predict_trajectory(input logic [31:0] s0, i0, r0);
    int unsigned cnt;
    logic [31:0] s, inf, r, l;
    logic [63:0] sv, ni, rs;
    cnt = epochs_q;
    if (cnt < 1) cnt = 1;
    if (cnt > 64) cnt = 64;
    s = s0;
    inf = i0;
    r = r0;
    l = neg_log2(17'h10000 - 17'(prob_q));
    trajectory_q.push_back('{6'd0, s, inf, r, cnt == 1});
    for (int t = 1; t < cnt; t++) begin
      sv = survival_frac(inf, l);
      ni = (64'(s) * ((64'd1 << 32) - sv)) >> 32;
      rs = 64'(r) + 64'(inf);
      if (ni > 64'(s)) ni = 64'(s);
      s = s - ni[31:0];
      r = rs > 64'hFFFFFFFF ? 32'hFFFFFFFF : rs[31:0];
      inf = ni[31:0];
      trajectory_q.push_back('{6'(t), s, inf, r, t + 1 == cnt});
    end
  endtask

  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready_i <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      out_ready_i <= 1'b0;
    end else if (rx_idle_en && ($urandom_range(0, 3) == 0)) begin
      rx_gap <= $urandom_range(0, 3);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    epoch_rec_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (trajectory_q.size() == 0) begin
        $display("%0t unexpected epoch %0d", $time, epoch_index_o);
        fail_cnt++;
      end else begin
        exp_r = trajectory_q.pop_front();
        if (exp_r != {epoch_index_o, susceptible_o, infected_o, recovered_o, last_epoch_o}) begin
          $display("%0t mismatch exp %h act %h", $time, exp_r,
                   {epoch_index_o, susceptible_o, infected_o, recovered_o, last_epoch_o});
          fail_cnt++;
        end
      end
    end
  end

  task automatic send_run(input logic [31:0] s0, i0, r0);
    int gap;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    initial_susceptible_i <= s0;
    initial_infected_i <= i0;
    initial_recovered_i <= r0;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_trajectory(s0, i0, r0);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic drain();
    while (trajectory_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CfgTransmit) prob_q = val;
    else epochs_q = val[6:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_pop();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h000FFFFF);
      2: return $urandom_range(0, 32'h00003FFF);
      default: return 32'hFFFFFFFF - $urandom_range(0, 255);
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_run(32'd1000 << 12, 32'd10 << 12, 32'd0);
    send_run(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    drain();
  endtask

  task automatic test_extremes();
    write_reg(CfgEpochs, 16'd0);
    send_run(32'd5 << 12, 32'd1 << 12, 32'd7);
    write_reg(CfgEpochs, 16'd1);
    send_run(32'hFFFFFFFF, 32'd0, 32'hFFFFFFFF);
    write_reg(CfgEpochs, 16'd127);
    write_reg(CfgTransmit, 16'd65535);
    send_run(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFF0000);
    write_reg(CfgEpochs, 16'd8);
    write_reg(CfgTransmit, 16'd0);
    send_run(32'd100 << 12, 32'd50 << 12, 32'd0);
    write_reg(CfgTransmit, 16'd32768);
    send_run(32'd0, 32'd1, 32'd0);
    send_run(32'h12345678, 32'd1, 32'hFFFFFFF0);
    send_run(32'hAAAAAAAA, 32'h55555555, 32'h0F0F0F0F);
    write_reg(CfgEpochs, 16'd64);
    write_reg(CfgTransmit, 16'd1);
    send_run(32'd10000 << 12, 32'd3 << 12, 32'd0);
    drain();
  endtask

  task automatic test_backpressure();
    write_reg(CfgEpochs, 16'd2);
    write_reg(CfgTransmit, 16'd655);
    hold_off = 400;
    for (int i = 0; i < 4; i++) send_run(rand_pop(), rand_pop(), rand_pop());
    drain();
  endtask

  task automatic test_random_runs(input int n);
    for (int i = 0; i < n; i++) begin
      if (i % 20 == 0) begin
        write_reg(CfgTransmit, 16'($urandom));
        write_reg(CfgEpochs, $urandom_range(0, 5) == 0 ? 16'($urandom_range(0, 127))
                                                       : 16'($urandom_range(1, 6)));
      end
      send_run(rand_pop(), rand_pop(), rand_pop());
    end
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_defaults();
    test_extremes();
    test_backpressure();
    test_random_runs(200);
    rx_idle_en = 1'b0;
    tx_idle_en = 1'b0;
    test_random_runs(50);
    if (fail_cnt == 0) begin
      $display("epidemic_chain_trajectory_top_tb: PASS");
    end else begin
      $display("epidemic_chain_trajectory_top_tb: FAIL");
    end
    $finish;
  end
endmodule

[epidemic_chain_trajectory_top.f]
+incdir+hdl
hdl/ect_pkg.sv
hdl/ect_mul.sv
hdl/ect_out.sv
hdl/epidemic_chain_trajectory_top.sv
verif/epidemic_chain_trajectory_top_tb.sv
